// File: design/motor_pulse_speed_regulator_core_defines.svh
// Assertion macros for the motor pulse speed regulator.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef MOTOR_PULSE_SPEED_REGULATOR_CORE_DEFINES_SVH
`define MOTOR_PULSE_SPEED_REGULATOR_CORE_DEFINES_SVH

`define MPSR_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mpsr assertion failed");

`define MPSR_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mpsr assertion failed");

`endif

// File: design/mpsr_pkg.sv
// Shared types, constants and codes of the motor pulse speed regulator.
// No dependencies.
`default_nettype none
package mpsr_pkg;

  localparam int STOP_PULSE_US   = 1000;
  localparam int MAX_PULSE_US    = 2000;
  localparam int MAX_RPM         = 7200;
  localparam int NO_HALL_STEP_US = 5;

  localparam int PULSE_W   = 12;
  localparam int RPM_W     = 14;
  localparam int SPEED_W   = 16;
  localparam int DIV_NUM_W = 16;
  localparam int DIV_DEN_W = 10;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);
  localparam int EMA_W     = SPEED_W + 1;
  localparam int SHIFT_W   = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 12;

  typedef logic [PULSE_W-1:0]          pulse_t;
  typedef logic [RPM_W-1:0]            rpm_t;
  typedef logic [SPEED_W-1:0]          speed_t;
  typedef logic [DIV_NUM_W-1:0]        div_num_t;
  typedef logic [DIV_DEN_W-1:0]        div_den_t;
  typedef logic signed [EMA_W-1:0]     ema_t;
  typedef logic [SHIFT_W-1:0]          shift_t;

  localparam logic [1:0] CMD_UPDATE = 2'd0;
  localparam logic [1:0] CMD_START  = 2'd1;
  localparam logic [1:0] CMD_STOP   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_HZ   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ARM_COUNT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RPM_PER_US  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_EMA_SHIFT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STARTUP     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_NO_HALL_MAX = 3'd7;

endpackage
`default_nettype wire

// File: design/mpsr_ema_shift.sv
// Bit-serial arithmetic right shifter for the speed filter difference.
// Depends on mpsr_pkg.
`default_nettype none
module mpsr_ema_shift (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  mpsr_pkg::ema_t    value,
  input  mpsr_pkg::shift_t  amount,
  output logic              done,
  output mpsr_pkg::ema_t    result
);
  import mpsr_pkg::*;

  logic   busy_r, busy_nxt;
  shift_t cnt_r, cnt_nxt;
  ema_t   sh_r, sh_nxt;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = amount;
      sh_nxt   = value;
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
        sh_nxt  = sh_r >>> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    sh_r <= sh_nxt;
  end

  assign done   = busy_r && (cnt_r == '0);
  assign result = sh_r;

endmodule
`default_nettype wire

// File: design/mpsr_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on mpsr_pkg.
`default_nettype none
module mpsr_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  mpsr_pkg::div_num_t  dividend,
  input  mpsr_pkg::div_den_t  divisor,
  output logic                done,
  output mpsr_pkg::div_num_t  quotient
);
  import mpsr_pkg::*;

  logic                 busy_r, busy_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  div_num_t             quo_r, quo_nxt;
  div_den_t             rem_r, rem_nxt;
  div_den_t             den_r, den_nxt;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;

  always_comb begin
    trial    = {rem_r, quo_r[DIV_NUM_W-1]};
    diff     = trial - {1'b0, den_r};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_NUM_W);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      den_nxt  = divisor;
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
        if (trial >= {1'b0, den_r}) begin
          rem_nxt = diff[DIV_DEN_W-1:0];
          quo_nxt = {quo_r[DIV_NUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[DIV_DEN_W-1:0];
          quo_nxt = {quo_r[DIV_NUM_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done     = busy_r && (cnt_r == '0);
  assign quotient = quo_r;

endmodule
`default_nettype wire

// File: design/motor_pulse_speed_regulator_core.sv
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready  | in_command, in_measured_rpm
// out     | output    | out_valid / out_ready| out_pulse_us, out_running
// cfg     | input     | cfg_wr_en            | cfg_index, cfg_data
// One item at a time. Stop, unknown and short update items go straight to the output state.
// Start items run the 16-step serial divider.
// Filtered update items run up to 15 filter shift steps plus the divider.
// Synchronous active-low reset; no clearing pass. A stalled output holds the next item back.
// Depends on mpsr_pkg, mpsr_ema_shift, mpsr_div and the defines header.
`default_nettype none
`include "motor_pulse_speed_regulator_core_defines.svh"
module motor_pulse_speed_regulator_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_command,
  input  mpsr_pkg::speed_t              in_measured_rpm,
  output logic                          out_valid,
  input  logic                          out_ready,
  output mpsr_pkg::pulse_t              out_pulse_us,
  output logic                          out_running,
  input  logic                          cfg_wr_en,
  input  logic [mpsr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mpsr_pkg::CFG_W-1:0]    cfg_data
);
  import mpsr_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EMA   = 3'd1;
  localparam logic [2:0] S_ERR   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_APPLY = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  localparam int ERR_W = SPEED_W + 2;
  localparam int NP_W  = PULSE_W + 2;

  logic [7:0]  hz_r, arm_r, max_step_r;
  logic [11:0] deadband_r, startup_r, no_hall_r;
  div_den_t    rpu_r;
  shift_t      ema_shift_r;

  logic [2:0] state_r, state_nxt;
  logic       active_r, active_nxt;
  rpm_t       target_r, target_nxt;
  pulse_t     pulse_r, pulse_nxt;
  speed_t     smooth_r, smooth_nxt;
  logic       op_start_r, op_start_nxt;
  logic       neg_r, neg_nxt;
  logic [7:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  pulse_t     out_pulse_r, out_pulse_nxt;
  logic       out_running_r, out_running_nxt;

  logic                    accept;
  logic                    ema_start, ema_done;
  ema_t                    ema_result;
  logic                    div_start, div_done;
  div_num_t                div_dividend, div_quotient;
  div_den_t                div_divisor;
  logic [7:0]              arms;
  div_den_t                rpu;
  logic [RPM_W-1:0]        hz60;
  logic [PULSE_W:0]        ramp;
  logic signed [ERR_W-1:0] err;
  logic [ERR_W-1:0]        err_neg;
  speed_t                  mag;
  div_num_t                q1;
  logic signed [NP_W-1:0]  np;
  rpm_t                    rpm;

  mpsr_ema_shift u_ema (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (ema_start),
    .value  ($signed({1'b0, in_measured_rpm}) - $signed({1'b0, smooth_r})),
    .amount (ema_shift_r),
    .done   (ema_done),
    .result (ema_result)
  );

  mpsr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hz_r        <= 8'd30;
      arm_r       <= 8'd2;
      deadband_r  <= 12'd20;
      rpu_r       <= 10'd10;
      max_step_r  <= 8'd10;
      ema_shift_r <= 4'd2;
      startup_r   <= 12'd1100;
      no_hall_r   <= 12'd1200;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_TARGET_HZ:   hz_r        <= cfg_data[7:0];
        REG_ARM_COUNT:   arm_r       <= cfg_data[7:0];
        REG_DEADBAND:    deadband_r  <= cfg_data;
        REG_RPM_PER_US:  rpu_r       <= cfg_data[DIV_DEN_W-1:0];
        REG_MAX_STEP:    max_step_r  <= cfg_data[7:0];
        REG_EMA_SHIFT:   ema_shift_r <= cfg_data[SHIFT_W-1:0];
        REG_STARTUP:     startup_r   <= cfg_data;
        REG_NO_HALL_MAX: no_hall_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    arms      = (arm_r == '0) ? 8'd1 : arm_r;
    rpu       = (rpu_r == '0) ? DIV_DEN_W'(1) : rpu_r;
    hz60      = {hz_r, 6'd0} - {4'd0, hz_r, 2'd0};
    ramp      = {1'b0, pulse_r} + (PULSE_W + 1)'(NO_HALL_STEP_US);
    err       = $signed({4'd0, target_r}) - $signed({2'd0, smooth_r});
    err_neg   = -err;
    mag       = err[ERR_W-1] ? err_neg[SPEED_W-1:0] : err[SPEED_W-1:0];
    q1        = (div_quotient == '0) ? DIV_NUM_W'(1) : div_quotient;
    rpm       = (div_quotient > DIV_NUM_W'(MAX_RPM)) ? RPM_W'(MAX_RPM)
                                                     : div_quotient[RPM_W-1:0];
    np        = neg_r ? $signed({2'd0, pulse_r}) - $signed({6'd0, step_r})
                      : $signed({2'd0, pulse_r}) + $signed({6'd0, step_r});
    div_dividend = (state_r == S_IDLE) ? {2'd0, hz60} : mag;
    div_divisor  = (state_r == S_IDLE) ? {2'd0, arms} : rpu;
  end

  always_comb begin
    state_nxt       = state_r;
    active_nxt      = active_r;
    target_nxt      = target_r;
    pulse_nxt       = pulse_r;
    smooth_nxt      = smooth_r;
    op_start_nxt    = op_start_r;
    neg_nxt         = neg_r;
    step_nxt        = step_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_pulse_nxt   = out_pulse_r;
    out_running_nxt = out_running_r;
    ema_start       = 1'b0;
    div_start       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_OUT;
          case (in_command)
            CMD_UPDATE: begin
              if (!active_r || target_r == '0) begin
                active_nxt = 1'b0;
                target_nxt = '0;
                pulse_nxt  = PULSE_W'(STOP_PULSE_US);
                smooth_nxt = '0;
              end else if (in_measured_rpm == '0) begin
                smooth_nxt = '0;
                pulse_nxt  = (ramp > {1'b0, no_hall_r}) ? no_hall_r : ramp[PULSE_W-1:0];
              end else if (smooth_r == '0) begin
                smooth_nxt = in_measured_rpm;
                state_nxt  = S_ERR;
              end else begin
                ema_start = 1'b1;
                state_nxt = S_EMA;
              end
            end
            CMD_START: begin
              div_start    = 1'b1;
              op_start_nxt = 1'b1;
              state_nxt    = S_DIV;
            end
            CMD_STOP: begin
              active_nxt = 1'b0;
              target_nxt = '0;
              pulse_nxt  = PULSE_W'(STOP_PULSE_US);
              smooth_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      S_EMA: begin
        if (ema_done) begin
          smooth_nxt = smooth_r + ema_result[SPEED_W-1:0];
          state_nxt  = S_ERR;
        end
      end
      S_ERR: begin
        if ({1'b0, mag} <= {5'd0, deadband_r}) begin
          state_nxt = S_OUT;
        end else begin
          neg_nxt      = err[ERR_W-1];
          div_start    = 1'b1;
          op_start_nxt = 1'b0;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (op_start_r) begin
            state_nxt  = S_OUT;
            target_nxt = rpm;
            if (rpm == '0) begin
              active_nxt = 1'b0;
              pulse_nxt  = PULSE_W'(STOP_PULSE_US);
              smooth_nxt = '0;
            end else begin
              active_nxt = 1'b1;
              pulse_nxt  = startup_r;
              smooth_nxt = '0;
            end
          end else begin
            step_nxt  = (q1 > {8'd0, max_step_r}) ? max_step_r : q1[7:0];
            state_nxt = S_APPLY;
          end
        end
      end
      S_APPLY: begin
        if (np < $signed(NP_W'(STOP_PULSE_US))) begin
          pulse_nxt = PULSE_W'(STOP_PULSE_US);
        end else if (np > $signed(NP_W'(MAX_PULSE_US))) begin
          pulse_nxt = PULSE_W'(MAX_PULSE_US);
        end else begin
          pulse_nxt = np[PULSE_W-1:0];
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_pulse_nxt   = pulse_r;
          out_running_nxt = active_r;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= 1'b0;
      target_r    <= '0;
      pulse_r     <= PULSE_W'(STOP_PULSE_US);
      smooth_r    <= '0;
      op_start_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      target_r    <= target_nxt;
      pulse_r     <= pulse_nxt;
      smooth_r    <= smooth_nxt;
      op_start_r  <= op_start_nxt;
      out_valid_r <= out_valid_nxt;
    end
    neg_r         <= neg_nxt;
    step_r        <= step_nxt;
    out_pulse_r   <= out_pulse_nxt;
    out_running_r <= out_running_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_pulse_us = out_pulse_r;
  assign out_running  = out_running_r;

  `MPSR_ASSERT_IMPL(a_idle_pulse, out_valid && !out_running, out_pulse_us == PULSE_W'(STOP_PULSE_US))
  `MPSR_ASSERT_IMPL(a_active_target, active_r, target_r != '0)
  `MPSR_ASSERT_IMPL(a_div_owner, div_done, state_r == S_DIV)
  `MPSR_ASSERT_NEXT(a_apply_clamp, state_r == S_APPLY, (pulse_r >= PULSE_W'(STOP_PULSE_US)) && (pulse_r <= PULSE_W'(MAX_PULSE_US)))

endmodule
`default_nettype wire

// File: bench/tb_motor_pulse_speed_regulator_core.sv
// Self-checking testbench for motor_pulse_speed_regulator_core: start, stop and speed-update
// items against an in-bench pulse regulator model, with random idling on both channels.
// Depends on mpsr_pkg and the core RTL.
`default_nettype none
module tb_motor_pulse_speed_regulator_core;
  timeunit 1ns;
  timeprecision 1ps;

  import mpsr_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_LIMIT = 5000;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct {
    logic [7:0] hz;
    logic [7:0] arms;
    logic [11:0] deadband;
    logic [9:0] rpm_per_us;
    logic [7:0] max_step;
    shift_t ema_shift;
    pulse_t startup;
    pulse_t no_hall_max;
  } regulator_cfg_t;

  typedef struct {
    logic [1:0] cmd;
    speed_t rpm;
  } esc_cmd_t;

  typedef struct {
    pulse_t pulse;
    logic running;
  } pulse_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_command = CMD_UPDATE;
  speed_t in_measured_rpm = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pulse_t out_pulse_us;
  logic out_running;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_TARGET_HZ;
  logic [CFG_W-1:0] cfg_data = '0;

  regulator_cfg_t cfg_now;
  logic run_flag;
  rpm_t tgt_rpm;
  pulse_t pulse_now;
  speed_t speed_avg;

  esc_cmd_t cmd_q[$];
  esc_cmd_t next_cmd;
  pulse_report_t expected_pulses[$];
  pulse_report_t oldest_pulse;

  int errors = 0;
  int unsigned cycles_run = 0;
  bit idle_en = 1'b1;
  int tx_gap = 0;
  int rx_wait = 0;
  int hold_reqs = 0;
  int hold_seen = 0;

  motor_pulse_speed_regulator_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_command(in_command),
    .in_measured_rpm(in_measured_rpm),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_pulse_us(out_pulse_us),
    .out_running(out_running),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles_run <= cycles_run + 1;
    if (cycles_run >= CYCLE_LIMIT) begin
      $display("tb_motor_pulse_speed_regulator_core: FAIL");
      $finish;
    end
  end

  task automatic flag_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycles_run, msg);
    errors++;
  endtask

  function automatic void halt_drive();
    run_flag = 1'b0;
    tgt_rpm = '0;
    pulse_now = pulse_t'(STOP_PULSE_US);
    speed_avg = '0;
  endfunction

  function automatic void regulate_pulse(input logic [1:0] cmd, input speed_t rpm_in);
    int arms, goal, n, d, err, mag, div, delta_us, lim, np;
    pulse_report_t r;
    case (cmd)
      CMD_START: begin
        arms = (cfg_now.arms == 0) ? 1 : int'(cfg_now.arms);
        goal = int'(cfg_now.hz) * 60 / arms;
        if (goal > MAX_RPM) goal = MAX_RPM;
        tgt_rpm = rpm_t'(goal);
        if (goal == 0) begin
          halt_drive();
        end else begin
          run_flag = 1'b1;
          pulse_now = cfg_now.startup;
          speed_avg = '0;
        end
      end
      CMD_STOP: halt_drive();
      CMD_UPDATE: begin
        if (!run_flag || tgt_rpm == 0) begin
          halt_drive();
        end else if (rpm_in == 0) begin
          n = int'(pulse_now) + NO_HALL_STEP_US;
          speed_avg = '0;
          pulse_now = (n > int'(cfg_now.no_hall_max)) ? cfg_now.no_hall_max : pulse_t'(n);
        end else begin
          if (speed_avg == 0) begin
            speed_avg = rpm_in;
          end else begin
            d = int'(rpm_in) - int'(speed_avg);
            speed_avg = speed_t'(int'(speed_avg) + (d >>> cfg_now.ema_shift));
          end
          err = int'(tgt_rpm) - int'(speed_avg);
          mag = (err < 0) ? -err : err;
          if (mag > int'(cfg_now.deadband)) begin
            div = (cfg_now.rpm_per_us == 0) ? 1 : int'(cfg_now.rpm_per_us);
            delta_us = err / div;
            if (delta_us == 0) delta_us = (err > 0) ? 1 : -1;
            lim = int'(cfg_now.max_step);
            if (delta_us > lim) delta_us = lim;
            if (delta_us < -lim) delta_us = -lim;
            np = int'(pulse_now) + delta_us;
            if (np < STOP_PULSE_US) np = STOP_PULSE_US;
            if (np > MAX_PULSE_US) np = MAX_PULSE_US;
            pulse_now = pulse_t'(np);
          end
        end
      end
      default: ;
    endcase
    r.pulse = pulse_now;
    r.running = run_flag;
    expected_pulses.push_back(r);
  endfunction

  // Input driver: one nonblocking update of each input per edge.
  always @(posedge clk) begin
    if (!in_valid || in_ready) begin
      if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        in_valid <= 1'b0;
      end else if (cmd_q.size() != 0) begin
        if (idle_en && $urandom_range(0, 4) == 0) begin
          tx_gap <= $urandom_range(0, 13);
          in_valid <= 1'b0;
        end else begin
          next_cmd = cmd_q.pop_front();
          in_valid <= 1'b1;
          in_command <= next_cmd.cmd;
          in_measured_rpm <= next_cmd.rpm;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      rx_wait <= HOLD_OFF_CYCLES;
      out_ready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      out_ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      rx_wait <= $urandom_range(0, 13);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_pulses.size() == 0) begin
        flag_mismatch("result item with nothing expected");
      end else begin
        oldest_pulse = expected_pulses.pop_front();
        if (out_pulse_us !== oldest_pulse.pulse)
          flag_mismatch($sformatf("pulse_us %0d, expected %0d", out_pulse_us,
                                  oldest_pulse.pulse));
        if (out_running !== oldest_pulse.running)
          flag_mismatch($sformatf("running %0b, expected %0b", out_running,
                                  oldest_pulse.running));
      end
    end
  end

  task automatic send_item(input logic [1:0] cmd, input speed_t rpm);
    esc_cmd_t c;
    c.cmd = cmd;
    c.rpm = rpm;
    regulate_pulse(cmd, rpm);
    cmd_q.push_back(c);
    while (cmd_q.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    int waited;
    waited = 0;
    while (expected_pulses.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic load_settings(input regulator_cfg_t s);
    settle();
    put_reg(REG_TARGET_HZ, CFG_W'(s.hz));
    put_reg(REG_ARM_COUNT, CFG_W'(s.arms));
    put_reg(REG_DEADBAND, s.deadband);
    put_reg(REG_RPM_PER_US, CFG_W'(s.rpm_per_us));
    put_reg(REG_MAX_STEP, CFG_W'(s.max_step));
    put_reg(REG_EMA_SHIFT, CFG_W'(s.ema_shift));
    put_reg(REG_STARTUP, s.startup);
    put_reg(REG_NO_HALL_MAX, s.no_hall_max);
    cfg_wr_en <= 1'b0;
    cfg_now = s;
  endtask

  function automatic regulator_cfg_t random_settings();
    regulator_cfg_t s;
    s.hz = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
    s.arms = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 16));
    s.deadband = ($urandom_range(0, 4) == 0) ? 12'($urandom_range(0, 4095))
                                             : 12'($urandom_range(0, 100));
    s.rpm_per_us = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
                                               : 10'($urandom_range(0, 40));
    s.max_step = 8'($urandom_range(0, 255));
    s.ema_shift = ($urandom_range(0, 3) == 0) ? shift_t'($urandom_range(0, 15))
                                              : shift_t'($urandom_range(0, 5));
    s.startup = ($urandom_range(0, 3) == 0) ? pulse_t'($urandom_range(0, 4095))
                                            : pulse_t'($urandom_range(1000, 2000));
    s.no_hall_max = pulse_t'($urandom_range(0, 4095));
    return s;
  endfunction

  function automatic speed_t near_target(input int spread);
    int m;
    m = int'(tgt_rpm) + $urandom_range(0, 2 * spread) - spread;
    if (m < 1) m = 1;
    if (m > 65535) m = 65535;
    return speed_t'(m);
  endfunction

  task automatic run_control_loop(input int count);
    int pick;
    send_item(CMD_START, speed_t'($urandom));
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (!run_flag && pick < 50) send_item(CMD_START, speed_t'($urandom));
      else if (pick < 3) send_item(CMD_STOP, speed_t'($urandom));
      else if (pick < 5) send_item(CMD_UNUSED, speed_t'($urandom));
      else if (pick < 8) send_item(CMD_START, speed_t'($urandom));
      else if (pick < 14) send_item(CMD_UPDATE, '0);
      else if (pick < 20) send_item(CMD_UPDATE, speed_t'($urandom));
      else send_item(CMD_UPDATE, near_target($urandom_range(0, 600)));
    end
  endtask

  task automatic test_directed();
    send_item(CMD_UPDATE, '0);
    send_item(CMD_UPDATE, 16'hFFFF);
    send_item(CMD_UNUSED, 16'hFFFF);
    send_item(CMD_STOP, '0);
    send_item(CMD_START, '0);
    repeat (3) send_item(CMD_UPDATE, '0);
    send_item(CMD_UPDATE, 16'hFFFF);
    send_item(CMD_UPDATE, 16'd1);
    send_item(CMD_UPDATE, 16'd900);
    send_item(CMD_UPDATE, 16'd915);
    send_item(CMD_UNUSED, 16'hAAAA);
    send_item(CMD_START, 16'h5555);
    send_item(CMD_STOP, 16'hFFFF);
    send_item(CMD_UPDATE, 16'd900);
  endtask

  task automatic test_register_extremes();
    load_settings('{8'd0, 8'd0, 12'd0, 10'd0, 8'd0, 4'd0, 12'd0, 12'd0});
    send_item(CMD_START, '0);
    send_item(CMD_UPDATE, 16'd100);
    load_settings('{8'd255, 8'd0, 12'd0, 10'd0, 8'd0, 4'd0, 12'd0, 12'd0});
    send_item(CMD_START, '0);
    send_item(CMD_UPDATE, '0);
    send_item(CMD_UPDATE, 16'd100);
    send_item(CMD_UPDATE, 16'd7200);
    send_item(CMD_UPDATE, 16'd50000);
    load_settings('{8'd255, 8'd255, 12'd4095, 10'd1023, 8'd255, 4'd15, 12'd4095, 12'd4095});
    send_item(CMD_START, '0);
    send_item(CMD_UPDATE, '0);
    send_item(CMD_UPDATE, 16'hFFFF);
    send_item(CMD_UPDATE, 16'd1);
    load_settings('{8'd255, 8'd1, 12'd0, 10'd1, 8'd255, 4'd15, 12'd1500, 12'd1000});
    send_item(CMD_START, '0);
    send_item(CMD_UPDATE, 16'd3);
    send_item(CMD_UPDATE, 16'd3);
    send_item(CMD_UPDATE, '0);
  endtask

  task automatic test_random_settings();
    for (int phase = 0; phase < 8; phase++) begin
      load_settings(random_settings());
      idle_en = ($urandom_range(0, 3) != 0);
      run_control_loop(48);
    end
    idle_en = 1'b1;
  endtask

  task automatic test_output_stall();
    settle();
    hold_reqs++;
    send_item(CMD_START, '0);
    repeat (15) send_item(CMD_UPDATE, near_target(300));
  endtask

  task automatic test_steady_stream();
    regulator_cfg_t s;
    s = random_settings();
    s.hz = 8'd200;
    s.arms = 8'd3;
    load_settings(s);
    idle_en = 1'b0;
    run_control_loop(60);
  endtask

  initial begin
    cfg_now = '{8'd30, 8'd2, 12'd20, 10'd10, 8'd10, 4'd2, 12'd1100, 12'd1200};
    halt_drive();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    test_directed();
    test_register_extremes();
    test_random_settings();
    test_output_stall();
    test_steady_stream();
    settle();
    repeat (40) @(posedge clk);
    if (expected_pulses.size() != 0)
      flag_mismatch($sformatf("%0d expected results never arrived", expected_pulses.size()));
    if (errors == 0) begin
      $display("tb_motor_pulse_speed_regulator_core: PASS");
    end else begin
      $display("tb_motor_pulse_speed_regulator_core: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: filelist.f
+incdir+design
design/mpsr_pkg.sv
design/mpsr_ema_shift.sv
design/mpsr_div.sv
design/motor_pulse_speed_regulator_core.sv
bench/tb_motor_pulse_speed_regulator_core.sv
